// File: rtl/rsw_pkg.sv
// shared types and constants for the running statistics block
package rsw_pkg;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_e;

  typedef struct packed {
    logic        cmd;
    logic [31:0] sample_value;
  } req_t;

  typedef struct packed {
    logic [31:0] sample_count;
    logic [31:0] minimum;
    logic [31:0] maximum;
    logic [31:0] mean_value;
    logic [31:0] std_deviation;
    logic        saturated;
  } rsp_t;

endpackage

// File: rtl/rsw_front.sv
// request intake: two-entry queue that decouples the port from the engine
module rsw_front import rsw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_stall_o,
  input  req_t req_i,
  output logic q_valid_o,
  input  logic q_pop_i,
  output req_t q_data_o
);

  req_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign req_stall_o = (cnt_q == 2'd2);
  assign push        = req_valid_i && !req_stall_o;
  assign pop         = q_pop_i && q_valid_o;
  assign q_valid_o   = (cnt_q != 2'd0);
  assign q_data_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("push into full queue");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> cnt_q != 2'd0) else $error("pop from empty queue");

endmodule

// File: rtl/rsw_back.sv
// statistics engine: welford update with serial divide and square root
module rsw_back import rsw_pkg::*; #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int FRAC_BITS    = 16,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  output logic q_pop_o,
  input  req_t q_data_i,
  output logic rsp_valid_o,
  input  logic rsp_stall_i,
  output rsp_t rsp_o
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int CW  = COUNT_WIDTH;
  localparam int DW  = SW + 1;          // difference width
  localparam int QCW = $clog2(65);

  typedef enum logic [3:0] {
    S_IDLE, S_MDIV, S_MEAN, S_MUL, S_ACC, S_VDIV, S_SQRT, S_OUT
  } state_e;

  state_e state_q;

  logic signed [SW-1:0] min_q, max_q, mean_q, x_q, old_mean_q;
  logic [CW-1:0]        count_q;
  logic [63:0]          dsum_q;
  logic                 sat_q;

  // shared shift-subtract divider (also used for the square root)
  logic [63:0]    num_q, quo_q, rem_q, den_q;
  logic [QCW-1:0] step_q;
  logic           neg_q;
  logic [DW-1:0]  a_q, b_q;
  logic [63:0]    root_q, bit_q;
  logic [127:0]   prod_full;
  logic [DW-1:0]  diff_new_mag, diff_old_mag;
  logic signed [DW:0] diff_old_s, diff_new_s, mean_sum;
  logic [64:0]    rem_sh, root_try;
  logic [64:0]    acc_sum;
  logic signed [SW-1:0] smp;
  logic [63:0]    prod_q;
  logic           prod_ovf_q;
  logic [31:0]    sd_q;

  assign smp        = SW'(q_data_i.sample_value);
  assign diff_old_s = {{2{x_q[SW-1]}}, x_q} - {{2{old_mean_q[SW-1]}}, old_mean_q};
  assign diff_new_s = {{2{x_q[SW-1]}}, x_q} - {{2{mean_q[SW-1]}}, mean_q};
  assign diff_old_mag = diff_old_s[DW] ? DW'(-diff_old_s) : diff_old_s[DW-1:0];
  assign diff_new_mag = diff_new_s[DW] ? DW'(-diff_new_s) : diff_new_s[DW-1:0];
  assign rem_sh     = {rem_q, num_q[63]};
  assign root_try   = {1'b0, root_q} + {1'b0, bit_q};
  assign acc_sum    = {1'b0, dsum_q} + {1'b0, prod_q};
  assign prod_full  = 128'(a_q) * 128'(b_q);
  assign mean_sum   = {{2{old_mean_q[SW-1]}}, old_mean_q}
                    + (neg_q ? -$signed((DW+1)'(quo_q)) : $signed((DW+1)'(quo_q)));

  assign q_pop_o = (state_q == S_IDLE) && q_valid_i && !rsp_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      min_q       <= '0;
      max_q       <= '0;
      mean_q      <= '0;
      dsum_q      <= '0;
      sat_q       <= 1'b0;
      rsp_valid_o <= 1'b0;
      rsp_o       <= '0;
      step_q      <= '0;
    end else begin
      if (rsp_valid_o && !rsp_stall_i) rsp_valid_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (q_pop_o) begin
            if (q_data_i.cmd == CMD_CLEAR) begin
              count_q <= '0; min_q <= '0; max_q <= '0; mean_q <= '0;
              dsum_q <= '0; sat_q <= 1'b0;
            end else if (count_q == {CW{1'b1}}) begin
              sat_q   <= 1'b1;
              state_q <= S_VDIV;
              num_q   <= dsum_q;
              den_q   <= 64'(count_q - 1'b1);
              rem_q   <= '0;
              step_q  <= '0;
            end else begin
              x_q        <= smp;
              old_mean_q <= mean_q;
              if (count_q == '0 || smp < min_q) min_q <= smp;
              if (count_q == '0 || smp > max_q) max_q <= smp;
              count_q <= count_q + 1'b1;
              state_q <= S_MDIV;
            end
          end
        end
        S_MDIV: begin
          // |x - old mean| / count, truncating
          neg_q  <= diff_old_s[DW];
          num_q  <= 64'(diff_old_mag);
          den_q  <= 64'(count_q);
          rem_q  <= '0;
          step_q <= '0;
          state_q <= S_MEAN;
        end
        S_MEAN: begin
          if (step_q == QCW'(64)) begin
            mean_q  <= mean_sum[SW-1:0];
            state_q <= S_MUL;
          end else begin
            if (rem_sh >= {1'b0, den_q}) begin
              rem_q <= 64'(rem_sh - {1'b0, den_q});
              quo_q <= {quo_q[62:0], 1'b1};
            end else begin
              rem_q <= rem_sh[63:0];
              quo_q <= {quo_q[62:0], 1'b0};
            end
            num_q  <= {num_q[62:0], 1'b0};
            step_q <= step_q + 1'b1;
          end
        end
        S_MUL: begin
          a_q     <= diff_new_mag;
          b_q     <= diff_old_mag;
          state_q <= S_ACC;
          step_q  <= '0;
        end
        S_ACC: begin
          if (step_q == '0) begin
            prod_q     <= prod_full[63:0];
            prod_ovf_q <= |prod_full[127:64];
            step_q     <= QCW'(1);
          end else begin
            if (prod_ovf_q || acc_sum[64]) begin
              dsum_q <= '1;
              sat_q  <= 1'b1;
              num_q  <= '1;
            end else begin
              dsum_q <= acc_sum[63:0];
              num_q  <= acc_sum[63:0];
            end
            den_q   <= 64'(count_q - 1'b1);
            rem_q   <= '0;
            step_q  <= '0;
            state_q <= S_VDIV;
          end
        end
        S_VDIV: begin
          if (count_q <= CW'(1)) begin
            sd_q    <= '0;
            state_q <= S_OUT;
          end else if (step_q == QCW'(64)) begin
            // quotient now in quo_q, start square root
            num_q   <= quo_q;
            root_q  <= '0;
            bit_q   <= 64'h4000_0000_0000_0000;
            state_q <= S_SQRT;
          end else begin
            if (rem_sh >= {1'b0, den_q}) begin
              rem_q <= 64'(rem_sh - {1'b0, den_q});
              quo_q <= {quo_q[62:0], 1'b1};
            end else begin
              rem_q <= rem_sh[63:0];
              quo_q <= {quo_q[62:0], 1'b0};
            end
            num_q  <= {num_q[62:0], 1'b0};
            step_q <= step_q + 1'b1;
          end
        end
        S_SQRT: begin
          // one result bit per cycle
          if (bit_q == '0) begin
            sd_q    <= root_q[31:0];
            state_q <= S_OUT;
          end else begin
            if ({1'b0, num_q} >= root_try) begin
              num_q  <= num_q - root_try[63:0];
              root_q <= (root_q >> 1) + bit_q;
            end else begin
              root_q <= root_q >> 1;
            end
            bit_q <= bit_q >> 2;
          end
        end
        S_OUT: begin
          if (!rsp_valid_o) begin
            rsp_valid_o         <= 1'b1;
            rsp_o.sample_count  <= 32'(count_q);
            rsp_o.minimum       <= 32'(min_q);
            rsp_o.maximum       <= 32'(max_q);
            rsp_o.mean_value    <= 32'(mean_q);
            rsp_o.std_deviation <= sd_q;
            rsp_o.saturated     <= sat_q;
            state_q             <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> state_q == S_IDLE) else $error("pop while busy");
  a_minmax: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT |-> min_q <= max_q) else $error("min above max");
  a_out_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_o) |-> $past(state_q) == S_OUT) else $error("stray result");

endmodule

// File: rtl/running_stats_welford.sv
// running mean, variance, min and max of a sample stream
// Each add request runs through the statistics engine: a 64-step serial divide for the
// mean, a multiply and accumulate, a 64-step serial divide for the variance and a 32-step
// square root (an add at full count skips the first two, a count of one the last two).
// The divides and the square root share one shift-subtract datapath. A clear request
// gives no result. A two-entry request queue lets the sender run ahead of the engine.
module running_stats_welford import rsw_pkg::*; #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int FRAC_BITS    = 16,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  logic q_valid, q_pop;
  req_t q_data;

  rsw_front u_front (
    .clk_i, .rst_ni,
    .req_valid_i (in_valid_i),
    .req_stall_o (in_stall_o),
    .req_i       (in_req_i),
    .q_valid_o   (q_valid),
    .q_pop_i     (q_pop),
    .q_data_o    (q_data)
  );

  rsw_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRAC_BITS    (FRAC_BITS),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_back (
    .clk_i, .rst_ni,
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_data_i    (q_data),
    .rsp_valid_o (out_valid_o),
    .rsp_stall_i (out_stall_i),
    .rsp_o       (out_rsp_o)
  );

endmodule

// File: dv/tb.sv
// testbench for the running statistics block: directed and random requests with a self-checking predictor
`timescale 1ns / 1ps

module tb;
  import rsw_pkg::*;

  localparam longint unsigned CycleLimit = 3000000;
  localparam int unsigned DrainCycles = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  req_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_rsp_o;

  running_stats_welford dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_req_i(in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o(out_rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicted statistics state
  longint unsigned count_q;
  longint signed min_q, max_q, mean_q;
  longint unsigned devsum_q;
  bit sat_q;

  rsp_t stats_q[$];
  int unsigned errors = 0;
  longint unsigned cycles = 0;
  bit steady = 1'b0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint unsigned mag(input longint signed v);
    return v < 0 ? 64'd0 - longint'(v) : v;
  endfunction

  task automatic clear_stats();
    count_q = 0;
    min_q = 0;
    max_q = 0;
    mean_q = 0;
    devsum_q = 0;
    sat_q = 1'b0;
  endtask

  task automatic predict(input req_t r);
    longint signed x, old_mean;
    longint unsigned a, b, prod, sd;
    logic [127:0] wide;
    rsp_t s;
    if (r.cmd == CMD_CLEAR) begin
      clear_stats();
      return;
    end
    if (count_q >= 64'hFFFF_FFFF) begin
      sat_q = 1'b1;
    end else begin
      x = longint'(signed'(r.sample_value));
      old_mean = mean_q;
      if (count_q == 0) begin
        min_q = x;
        max_q = x;
      end else begin
        if (x < min_q) min_q = x;
        if (x > max_q) max_q = x;
      end
      count_q++;
      mean_q = old_mean + (x - old_mean) / longint'(count_q);
      a = mag(x - mean_q);
      b = mag(x - old_mean);
      wide = {64'd0, a} * {64'd0, b};
      if (wide[127:64] != 0) begin
        prod = '1;
        sat_q = 1'b1;
      end else begin
        prod = wide[63:0];
      end
      if (prod > 64'hFFFF_FFFF_FFFF_FFFF - devsum_q) begin
        devsum_q = '1;
        sat_q = 1'b1;
      end else begin
        devsum_q += prod;
      end
    end
    sd = (count_q > 1) ? int_sqrt(devsum_q / (count_q - 1)) : 0;
    s.sample_count = count_q[31:0];
    s.minimum = min_q[31:0];
    s.maximum = max_q[31:0];
    s.mean_value = mean_q[31:0];
    s.std_deviation = sd[31:0];
    s.saturated = sat_q;
    stats_q.push_back(s);
  endtask

  task automatic send(input logic cmd, input logic [31:0] val);
    req_t r;
    r.cmd = cmd;
    r.sample_value = val;
    while (!steady && $urandom_range(99) < 21) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    predict(r);
  endtask

  task automatic add(input logic [31:0] val);
    send(CMD_ADD, val);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (stats_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL running_stats_welford");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99) < 21);
  end

  // result checker
  always @(posedge clk_i) begin
    rsp_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (stats_q.size() == 0) begin
        report("unexpected result", out_rsp_o.sample_count, '0);
      end else begin
        w = stats_q.pop_front();
        if (out_rsp_o.sample_count !== w.sample_count)
          report("sample_count", out_rsp_o.sample_count, w.sample_count);
        if (out_rsp_o.minimum !== w.minimum) report("minimum", out_rsp_o.minimum, w.minimum);
        if (out_rsp_o.maximum !== w.maximum) report("maximum", out_rsp_o.maximum, w.maximum);
        if (out_rsp_o.mean_value !== w.mean_value)
          report("mean_value", out_rsp_o.mean_value, w.mean_value);
        if (out_rsp_o.std_deviation !== w.std_deviation)
          report("std_deviation", out_rsp_o.std_deviation, w.std_deviation);
        if (out_rsp_o.saturated !== w.saturated)
          report("saturated", {31'd0, out_rsp_o.saturated}, {31'd0, w.saturated});
      end
    end
  end

  task automatic test_directed();
    add(32'h0001_8000);                 // single sample gives zero deviation
    add(32'hFFFE_8000);
    add(32'h0000_0000);
    send(CMD_CLEAR, 32'hFFFF_FFFF);
    add(32'h7FFF_FFFF);
    add(32'h8000_0000);                 // widest spread
    add(32'h7FFF_FFFF);
    add(32'h8000_0000);                 // deviation sum comes close to the 64-bit limit here
    add(32'h0000_0001);
    send(CMD_CLEAR, 32'h0000_0000);     // clear drops the saturated flag too
    add(32'h8000_0000);
    add(32'h8000_0000);
    add(32'hFFFF_FFFF);
    add(32'h0000_0001);
    send(CMD_CLEAR, 32'h5555_AAAA);
    send(CMD_CLEAR, 32'hAAAA_5555);
    add(32'h7FFF_FFFF);
    add(32'h7FFF_FFFE);
    add(32'h0000_0000);
    add(32'hFFFF_0000);
    wait_drained();
  endtask

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
      2: return $urandom_range(255) - 128;
      3: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3)
                                  : 32'h8000_0000 + $urandom_range(3);
      default: return $urandom_range(32'h0400_0000) - 32'h0200_0000;
    endcase
  endfunction

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 4) send(CMD_CLEAR, $urandom);
      else add(pick_sample());
    end
  endtask

  task automatic test_no_idle(input int n);
    steady = 1'b1;
    test_random(n);
    steady = 1'b0;
  endtask

  task automatic test_pause();
    wait_drained();
    repeat ($urandom_range(40, 5)) @(posedge clk_i);
    test_random(50);
  endtask

  initial begin
    clear_stats();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(700);
    test_pause();
    test_no_idle(300);
    test_random(600);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && stats_q.size() == 0) begin
      $display("PASS running_stats_welford");
    end else begin
      $display("FAIL running_stats_welford");
    end
    $finish;
  end

endmodule
